FILE: hw/rtl/aerc_pkg.sv
package aerc_pkg;

  localparam logic [2:0] REG_BELOW = 3'd0;
  localparam logic [2:0] REG_B1    = 3'd1;
  localparam logic [2:0] REG_B2    = 3'd2;
  localparam logic [2:0] REG_B3    = 3'd3;
  localparam logic [2:0] REG_B4    = 3'd4;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [40:0] LN2X32    = 41'd95265423104;
  localparam logic [21:0] A3_Q32    = 22'd3325478;
  localparam logic [31:0] ALPHA_Q32 = 32'd31341891;
  localparam logic signed [43:0] C1_Q32 = 44'sd57945980771;
  localparam logic signed [43:0] C2_Q32 = 44'sd70093866271;
  localparam logic signed [43:0] C3_Q32 = 44'sd57962731143;
  localparam logic [25:0] K1_Q32    = 26'd35862977;
  localparam logic [25:0] K2_Q32    = 26'd10222022;
  localparam logic [25:0] K3_Q32    = 26'd12841952;
  localparam logic [25:0] K4_Q32    = 26'd12584254;
  localparam logic [23:0] B3_Q32    = 24'd7086696;
  localparam logic [23:0] B4_Q32    = 24'd9491878;
  localparam logic [26:0] SCALE_Q24 = 27'd65884176;
  localparam logic [63:0] BOUND1    = 64'd386547057;
  localparam logic [63:0] BOUND2    = 64'd38654705664;
  localparam logic [63:0] BOUND3    = 64'd42949672960000;
  localparam logic [63:0] ONE_Q32   = 64'd4294967296;
  localparam logic [31:0] THR_RESET = 32'd8590;

  typedef struct packed {
    logic [2:0] region;
    logic       below;
    logic       zero;
  } tag_t;

  typedef logic [31:0] log_tab_t [0:64];

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1+i/64) in Q.32 via 2*atanh series
  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    logic [63:0] z, z2, p, s;
    for (int i = 0; i <= 64; i++) begin
      z = udiv64(64'(i) << 32, 64'(128 + i));
      z2 = (z * z) >> 32;
      p = z;
      s = '0;
      for (int k = 0; k < 16; k++) begin
        s = s + udiv64(p, 64'(2 * k + 1));
        p = (p * z2) >> 32;
      end
      t[i] = 32'(s << 1);
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

FILE: hw/rtl/alpha_em_running_coupling.sv
// Running electromagnetic coupling alpha(q). Takes signed Q15.16 momentum,
// returns unsigned Q0.32 alpha and the q2 band used (0 when q2 is below the
// q2_threshold register). Fully pipelined: one transaction per cycle unless
// the output stalls. The path to the output register is 14 stages of
// squaring, three parallel table-interpolated log units and the constant
// products, then a 32-stage restoring divider, one quotient bit per stage,
// and the output register. An output stall holds the whole pipeline.
module alpha_em_running_coupling
  import aerc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_momentum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_alpha,
  output logic [2:0]  out_region
);

  logic adv;
  logic [31:0] thr_r;
  logic v_r [0:12];
  tag_t tag_r [2:12];

  logic [31:0] mag0_r;
  logic [63:0] r2_1_r, r2_2_r;
  logic [44:0] pplo2_r, pphi2_r;
  logic [63:0] lx3_r [0:2];
  logic [5:0]  e4_r [0:2], e5_r [0:2];
  logic [5:0]  idx4_r [0:2];
  logic [31:0] fr4_r [0:2], fr5_r [0:2], lo5_r [0:2];
  logic [26:0] df5_r [0:2];
  logic [39:0] base6_r [0:2], ln7_r [0:2];
  logic [58:0] prod6_r [0:2];
  logic signed [40:0] lq8_r, p8_r, p38_r;
  logic [39:0] am9_r, pm9_r;
  logic an9_r, pn9_r, an10_r, pn10_r;
  logic [25:0] kc9_r;
  logic [23:0] bc9_r, bc10_r, bc11_r;
  logic [41:0] alo10_r, ahi10_r;
  logic [45:0] plo10_r, phi10_r;
  logic signed [39:0] sa11_r, sp11_r;
  logic [39:0] d12_r;

  logic        dv_v_r [0:32];
  tag_t        dv_tag_r [0:32];
  logic        dv_sat_r [0:32];
  logic [39:0] dv_d_r [0:32];
  logic [40:0] dv_rem_r [0:32];
  logic [31:0] dv_lo_r [0:32];
  logic [31:0] dv_q_r [0:32];

  logic        out_valid_r;
  logic [31:0] out_alpha_r;
  logic [2:0]  out_region_r;

  tag_t tag2_nxt;
  logic [63:0] ssum3_nxt;
  logic signed [43:0] lqx9, arg9, pl9;
  logic [43:0] aabs9, pabs9;
  logic [61:0] asum11;
  logic [65:0] psum11;
  logic signed [40:0] rp12, dd12;
  logic [63:0] n13;
  logic [31:0] alpha_nxt;

  assign adv = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign out_valid = out_valid_r;
  assign out_alpha = out_alpha_r;
  assign out_region = out_region_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= 12; i++) v_r[i] <= 1'b0;
      for (int j = 0; j <= 32; j++) dv_v_r[j] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i <= 12; i++) v_r[i] <= v_r[i-1];
      dv_v_r[0] <= v_r[12];
      for (int j = 1; j <= 32; j++) dv_v_r[j] <= dv_v_r[j-1];
      out_valid_r <= dv_v_r[32];
    end
  end

  // band select
  always_comb begin
    tag2_nxt.below = r2_1_r < {32'b0, thr_r};
    tag2_nxt.zero = r2_1_r == '0;
    if (tag2_nxt.below) tag2_nxt.region = REG_BELOW;
    else if (r2_1_r < BOUND1) tag2_nxt.region = REG_B1;
    else if (r2_1_r < BOUND2) tag2_nxt.region = REG_B2;
    else if (r2_1_r < BOUND3) tag2_nxt.region = REG_B3;
    else tag2_nxt.region = REG_B4;
    ssum3_nxt = {19'b0, pplo2_r} + {1'b0, pphi2_r, 18'b0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag0_r <= in_momentum[31] ? 32'(-in_momentum) : in_momentum;
      r2_1_r <= {32'b0, mag0_r} * {32'b0, mag0_r};
      r2_2_r <= r2_1_r;
      tag_r[2] <= tag2_nxt;
      pplo2_r <= {27'b0, r2_1_r[17:0]} * {18'b0, SCALE_Q24};
      pphi2_r <= {27'b0, r2_1_r[35:18]} * {18'b0, SCALE_Q24};
      for (int i = 3; i <= 12; i++) tag_r[i] <= tag_r[i-1];
      lx3_r[0] <= r2_2_r;
      lx3_r[1] <= r2_2_r + ONE_Q32;
      lx3_r[2] <= {25'b0, ssum3_nxt[62:24]} + ONE_Q32;
    end
  end

  // three log lanes: ln(r2), ln(r2+1), ln(3.927 r2 + 1)
  for (genvar g = 0; g < 3; g++) begin : g_log
    logic [5:0]  e_nxt;
    logic [63:0] m_nxt;
    always_comb begin
      e_nxt = '0;
      for (int b = 0; b < 64; b++) begin
        if (lx3_r[g][b]) e_nxt = 6'(b);
      end
      m_nxt = lx3_r[g] << (6'd63 - e_nxt);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        e4_r[g] <= e_nxt;
        idx4_r[g] <= m_nxt[62:57];
        fr4_r[g] <= m_nxt[56:25];
        e5_r[g] <= e4_r[g];
        fr5_r[g] <= fr4_r[g];
        lo5_r[g] <= LOG_TAB[{1'b0, idx4_r[g]}];
        df5_r[g] <= 27'(LOG_TAB[{1'b0, idx4_r[g]} + 7'd1] - LOG_TAB[{1'b0, idx4_r[g]}]);
        base6_r[g] <= {34'b0, e5_r[g]} * {8'b0, LN2_Q32} + {8'b0, lo5_r[g]};
        prod6_r[g] <= {32'b0, df5_r[g]} * {27'b0, fr5_r[g]};
        ln7_r[g] <= base6_r[g] + {13'b0, prod6_r[g][58:32]};
      end
    end
  end

  always_comb begin
    lqx9 = {{3{lq8_r[40]}}, lq8_r};
    case (tag_r[8].region) inside
      REG_B2: arg9 = C2_Q32 + (lqx9 <<< 1);
      REG_B3, REG_B4: arg9 = C3_Q32 + lqx9 + (lqx9 <<< 1);
      default: arg9 = C1_Q32 + lqx9;
    endcase
    pl9 = (tag_r[8].region == REG_B2) ? {{3{p38_r[40]}}, p38_r} : {{3{p8_r[40]}}, p8_r};
    aabs9 = arg9[43] ? 44'(-arg9) : 44'(arg9);
    pabs9 = pl9[43] ? 44'(-pl9) : 44'(pl9);
    asum11 = {20'b0, alo10_r} + {ahi10_r, 20'b0};
    psum11 = {20'b0, plo10_r} + {phi10_r, 20'b0};
    rp12 = 41'(sa11_r) + 41'(sp11_r) + $signed({17'b0, bc11_r});
    dd12 = $signed(41'(ONE_Q32)) - rp12;
    n13 = {ALPHA_Q32, 32'b0} + {25'b0, d12_r[39:1]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lq8_r <= $signed({1'b0, ln7_r[0]}) - $signed(LN2X32);
      p8_r <= $signed({1'b0, ln7_r[1]}) - $signed(LN2X32);
      p38_r <= $signed({1'b0, ln7_r[2]}) - $signed(LN2X32);
      am9_r <= aabs9[39:0];
      an9_r <= arg9[43];
      pm9_r <= pabs9[39:0];
      pn9_r <= pl9[43];
      case (tag_r[8].region)
        REG_B2: begin kc9_r <= K2_Q32; bc9_r <= '0; end
        REG_B3: begin kc9_r <= K3_Q32; bc9_r <= B3_Q32; end
        REG_B4: begin kc9_r <= K4_Q32; bc9_r <= B4_Q32; end
        default: begin kc9_r <= K1_Q32; bc9_r <= '0; end
      endcase
      alo10_r <= {22'b0, am9_r[19:0]} * {20'b0, A3_Q32};
      ahi10_r <= {22'b0, am9_r[39:20]} * {20'b0, A3_Q32};
      plo10_r <= {26'b0, pm9_r[19:0]} * {20'b0, kc9_r};
      phi10_r <= {26'b0, pm9_r[39:20]} * {20'b0, kc9_r};
      an10_r <= an9_r;
      pn10_r <= pn9_r;
      bc10_r <= bc9_r;
      sa11_r <= an10_r ? -$signed({10'b0, asum11[61:32]}) : $signed({10'b0, asum11[61:32]});
      sp11_r <= pn10_r ? -$signed({6'b0, psum11[65:32]}) : $signed({6'b0, psum11[65:32]});
      bc11_r <= bc10_r;
      d12_r <= (dd12 < 41'sd1) ? 40'd1 : dd12[39:0];
      dv_tag_r[0] <= tag_r[12];
      dv_d_r[0] <= d12_r;
      dv_sat_r[0] <= {8'b0, n13[63:32]} >= d12_r;
      dv_rem_r[0] <= {9'b0, n13[63:32]};
      dv_lo_r[0] <= n13[31:0];
      dv_q_r[0] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 1; j <= 32; j++) begin : g_div
    logic [40:0] t_nxt;
    logic        ge_nxt;
    always_comb begin
      t_nxt = {dv_rem_r[j-1][39:0], dv_lo_r[j-1][31]};
      ge_nxt = t_nxt >= {1'b0, dv_d_r[j-1]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[j] <= ge_nxt ? t_nxt - {1'b0, dv_d_r[j-1]} : t_nxt;
        dv_q_r[j] <= {dv_q_r[j-1][30:0], ge_nxt};
        dv_lo_r[j] <= {dv_lo_r[j-1][30:0], 1'b0};
        dv_d_r[j] <= dv_d_r[j-1];
        dv_sat_r[j] <= dv_sat_r[j-1];
        dv_tag_r[j] <= dv_tag_r[j-1];
      end
    end
  end

  always_comb begin
    if (dv_tag_r[32].below) alpha_nxt = ALPHA_Q32;
    else if (dv_tag_r[32].zero) alpha_nxt = '0;
    else if (dv_sat_r[32]) alpha_nxt = '1;
    else alpha_nxt = dv_q_r[32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_alpha_r <= alpha_nxt;
      out_region_r <= dv_tag_r[32].region;
    end
  end

  a_below_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == REG_BELOW |-> out_alpha == ALPHA_Q32)
    else $error("below-threshold transaction lost constant alpha");

  a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_region <= REG_B4)
    else $error("region code out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(dv_d_r[32]) && $stable(out_alpha))
    else $error("pipeline moved during stall");

endmodule

FILE: tb/alpha_em_running_coupling_checker.sv
`timescale 1ns / 1ps

module alpha_em_running_coupling_checker
  import aerc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic signed [31:0] in_momentum,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [31:0]       out_alpha,
  input  logic [2:0]        out_region,
  output int                errors,
  output int                pending
);

  localparam logic [63:0] LN2        = 64'd2977044472;
  localparam logic [63:0] LN2_32     = 64'd95265423104;
  localparam logic [63:0] A3         = 64'd3325478;
  localparam logic [63:0] ALPHA_FS   = 64'd31341891;
  localparam longint      C_LOW      = 64'sd57945980771;
  localparam longint      C_MID      = 64'sd70093866271;
  localparam longint      C_HIGH     = 64'sd57962731143;
  localparam logic [63:0] K_LOW      = 64'd35862977;
  localparam logic [63:0] K_MID      = 64'd10222022;
  localparam logic [63:0] K_HIGH     = 64'd12841952;
  localparam logic [63:0] K_TOP      = 64'd12584254;
  localparam longint      B_HIGH     = 64'sd7086696;
  localparam longint      B_TOP      = 64'sd9491878;
  localparam logic [63:0] SCALE_MID  = 64'd65884176;
  localparam logic [63:0] EDGE_LOW   = 64'd386547057;
  localparam logic [63:0] EDGE_MID   = 64'd38654705664;
  localparam logic [63:0] EDGE_HIGH  = 64'd42949672960000;
  localparam logic [63:0] UNIT       = 64'd4294967296;

  typedef struct {
    logic [31:0] alpha;
    logic [2:0]  region;
  } coupling_t;

  logic [63:0] ln_tab [0:64];
  logic [63:0] q2_floor;
  coupling_t   coupling_q[$];

  assign pending = coupling_q.size();

  initial begin
    logic [63:0] z, z2, p, s;
    for (int i = 0; i <= 64; i++) begin
      z = (64'(i) << 32) / 64'(128 + i);
      z2 = (z * z) >> 32;
      p = z;
      s = '0;
      for (int k = 0; k < 16; k++) begin
        s = s + p / 64'(2 * k + 1);
        p = (p * z2) >> 32;
      end
      ln_tab[i] = s << 1;
    end
  end

  function automatic logic [63:0] nat_log(input logic [63:0] x);
    int e;
    logic [63:0] m, frac, rem, lo, hi;
    int idx;
    e = 63;
    if (x == 0) return 0;
    while (x[e] == 1'b0) e--;
    m = x << (63 - e);
    frac = m & 64'h7FFF_FFFF_FFFF_FFFF;
    idx = int'(frac >> 57);
    rem = (frac >> 25) & 64'hFFFF_FFFF;
    lo = ln_tab[idx];
    hi = ln_tab[idx + 1];
    return 64'(e) * LN2 + lo + (((hi - lo) * rem) >> 32);
  endfunction

  function automatic longint scaled(input longint a, input logic [63:0] c);
    logic [63:0] mag, p;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    p = (mag * c) >> 32;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic coupling_t running_alpha(input logic [31:0] v);
    coupling_t r;
    logic [63:0] mag, q2, s, quo, d;
    longint lq, lp, lp3, rp, dd;
    mag = v[31] ? (UNIT - 64'(v)) : 64'(v);
    q2 = mag * mag;
    if (q2 < q2_floor) begin
      r.alpha = ALPHA_FS[31:0];
      r.region = REG_BELOW;
      return r;
    end
    if (q2 < EDGE_LOW) r.region = REG_B1;
    else if (q2 < EDGE_MID) r.region = REG_B2;
    else if (q2 < EDGE_HIGH) r.region = REG_B3;
    else r.region = REG_B4;
    if (q2 == 0) begin
      r.alpha = '0;
      return r;
    end
    lq = longint'(nat_log(q2)) - longint'(LN2_32);
    lp = longint'(nat_log(q2 + UNIT)) - longint'(LN2_32);
    case (r.region)
      REG_B1: rp = scaled(C_LOW + lq, A3) + scaled(lp, K_LOW);
      REG_B2: begin
        s = (q2 * SCALE_MID) >> 24;
        lp3 = longint'(nat_log(s + UNIT)) - longint'(LN2_32);
        rp = scaled(C_MID + 2 * lq, A3) + scaled(lp3, K_MID);
      end
      REG_B3: rp = scaled(C_HIGH + 3 * lq, A3) + B_HIGH + scaled(lp, K_HIGH);
      default: rp = scaled(C_HIGH + 3 * lq, A3) + B_TOP + scaled(lp, K_TOP);
    endcase
    dd = longint'(UNIT) - rp;
    if (dd < 1) dd = 1;
    d = 64'(dd);
    quo = ((ALPHA_FS << 32) + d / 2) / d;
    r.alpha = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    coupling_t want;
    if (!rst_n) begin
      q2_floor <= 64'(THR_RESET);
      coupling_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) q2_floor <= 64'(cfg_wdata);
      if (in_valid && !in_stall) coupling_q.push_back(running_alpha(in_momentum));
      if (out_valid && !out_stall) begin
        if (coupling_q.size() == 0) begin
          $error("unexpected transaction: alpha %0d region %0d", out_alpha, out_region);
          errors++;
        end else begin
          want = coupling_q.pop_front();
          if (out_alpha !== want.alpha) begin
            $error("alpha: expected %0d actual %0d", want.alpha, out_alpha);
            errors++;
          end
          if (out_region !== want.region) begin
            $error("region: expected %0d actual %0d", want.region, out_region);
            errors++;
          end
        end
      end
    end
  end

endmodule

FILE: tb/alpha_em_running_coupling_tb.sv
`timescale 1ns / 1ps

module alpha_em_running_coupling_tb;
  import aerc_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 60;
  localparam int PHASE_N  = 340;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [31:0]       cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic signed [31:0] in_momentum = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [31:0]       out_alpha;
  logic [2:0]        out_region;
  int                errors, pending;
  int                send_idle = 0, recv_idle = 0;
  bit                hold_req = 0;
  int                quiet = 0;

  always #5 clk = ~clk;

  alpha_em_running_coupling u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_momentum(in_momentum),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_alpha(out_alpha), .out_region(out_region)
  );

  alpha_em_running_coupling_checker u_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_momentum(in_momentum),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_alpha(out_alpha), .out_region(out_region),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        repeat (300) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_momentum(input logic [31:0] m);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_momentum <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_floor(input logic [31:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_momentum();
    logic [31:0] mag;
    case ($urandom_range(5))
      0: return $urandom;
      1: mag = $urandom_range(200);
      2: mag = $urandom_range(19660, 93);
      3: mag = $urandom_range(196607, 19661);
      4: mag = $urandom_range(6553599, 196608);
      default: mag = $urandom_range(32'h8000_0000, 6553600);
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  initial begin
    logic [31:0] floors [5];
    logic [31:0] edges [$];
    floors = '{THR_RESET, 32'd0, 32'hFFFF_FFFF, $urandom, 32'd1};
    edges = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'd92, 32'd93, -32'sd93, 32'd19660, 32'd19661, 32'd196607,
              32'd196608, -32'sd196608, 32'd6553599, 32'd6553600,
              -32'sd6553600, 32'd65536, 32'h5555_5555, 32'hAAAA_AAAA};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_floor(floors[ph]);
      send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 46) : 0;
      recv_idle = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 46) : 0;
      foreach (edges[i]) if (ph == 0 || i < 3) push_momentum(edges[i]);
      for (int n = 0; n < PHASE_N; n++) begin
        if (ph == 2 && n == 40) hold_req = 1;
        if (ph == 1 && n == 150) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        push_momentum(pick_momentum());
      end
    end
    in_valid <= 1'b0;
    recv_idle = 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: alpha_em_running_coupling.f
hw/rtl/aerc_pkg.sv
hw/rtl/alpha_em_running_coupling.sv
tb/alpha_em_running_coupling_checker.sv
tb/alpha_em_running_coupling_tb.sv
